// File: rtl/triangle_uv_tangent_core_assert.svh
// Assertion macros for the triangle tangent core.
// Used by the top level only; empty bodies when SYNTH is defined.
`ifndef TRIANGLE_UV_TANGENT_CORE_ASSERT_SVH
`define TRIANGLE_UV_TANGENT_CORE_ASSERT_SVH
`ifndef SYNTH
`define TUT_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tangent core assertion failed");
`define TUT_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tangent core assertion failed");
`else
`define TUT_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define TUT_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

// File: rtl/tut_pkg.sv
// Shared constants for the triangle tangent core.
// No dependencies.
`default_nettype none
package tut_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_WIDTH   = 32;
  localparam int MUL_CHUNK   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int STEP_BITS   = 5;
  localparam int ROOT_STEPS  = 32;
  localparam int QUOT_BITS   = 32;
  localparam logic [1:0] LAST_CORNER = 2'd2;
endpackage
`default_nettype wire

// File: rtl/triangle_uv_tangent_core.sv
// Triangle tangent core: one corner word per cycle while the job queue has room;
// a result word on every third corner. Back end per triangle: chunked products,
// magnitudes, normalizing, squares, bit-serial square root and divide, then
// output load; with UVs off or a zero tangent vector it skips to the output load.
// Synchronous active-high reset clears uv_present, corner count and queues.
`default_nettype none
`include "triangle_uv_tangent_core_assert.svh"
module triangle_uv_tangent_core #(
  parameter int COORD_WIDTH = tut_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = tut_pkg::FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z,
  input  wire logic signed [COORD_WIDTH-1:0] tex_u,
  input  wire logic signed [COORD_WIDTH-1:0] tex_v,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [tut_pkg::OUT_WIDTH-1:0] tangent_x,
  output logic signed [tut_pkg::OUT_WIDTH-1:0] tangent_y,
  output logic signed [tut_pkg::OUT_WIDTH-1:0] tangent_z,
  output logic                               degenerate
);
  localparam int JW = 10 * (COORD_WIDTH + 1) + 1;
  localparam logic signed [tut_pkg::OUT_WIDTH-1:0] UNIT = 1 << 30;

  logic          uv_present;
  logic          fj_valid, fj_ready;
  logic [JW-1:0] fj_data;
  logic          bj_valid, bj_ready;
  logic [JW-1:0] bj_data;
  logic          tan_zero;
  logic          tan_in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      uv_present <= cfg_data;
    end
  end

  tut_front #(.CW(COORD_WIDTH)) u_front (
    .clk, .rst, .uv_present, .in_valid, .in_ready,
    .pos_x, .pos_y, .pos_z, .tex_u, .tex_v,
    .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
  );

  tut_queue #(.W(JW)) u_queue (
    .clk, .rst,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj_data),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj_data)
  );

  tut_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk, .rst,
    .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
    .out_valid, .out_ready, .tangent_x, .tangent_y, .tangent_z, .degenerate
  );

  assign tan_zero = (tangent_x == '0) && (tangent_y == '0) && (tangent_z == '0);
  assign tan_in_range = (tangent_x <= UNIT) && (tangent_x >= -UNIT) &&
                        (tangent_y <= UNIT) && (tangent_y >= -UNIT) &&
                        (tangent_z <= UNIT) && (tangent_z >= -UNIT);

  `TUT_ASSERT_IMP(a_dgn_zero, clk, rst, out_valid && degenerate, tan_zero)
  `TUT_ASSERT_IMP(a_unit_range, clk, rst, out_valid && !degenerate, tan_in_range)
  `TUT_ASSERT_NXT(a_cfg_write, clk, rst, cfg_valid, uv_present == $past(cfg_data))
endmodule
`default_nettype wire

// File: rtl/tut_queue.sv
// Short job queue between the corner front end and the tangent back end.
// Uses tut_pkg for its depth.
`default_nettype none
module tut_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output logic [W-1:0]      rd_data
);
  localparam int D   = tut_pkg::QUEUE_DEPTH;
  localparam int PW  = (D > 1) ? $clog2(D) : 1;
  localparam int CNW = $clog2(D + 1);

  logic [W-1:0]   mem [D];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CNW-1:0] count;
  logic           do_wr;
  logic           do_rd;

  assign wr_ready = (count != CNW'(D));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(D - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(D - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/tut_front.sv
// Corner front end: holds the first two corners and forms edge and UV deltas.
// Uses tut_pkg; feeds tut_queue.
`default_nettype none
module tut_front #(
  parameter int CW = tut_pkg::COORD_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 uv_present,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [CW-1:0] pos_x,
  input  wire logic signed [CW-1:0] pos_y,
  input  wire logic signed [CW-1:0] pos_z,
  input  wire logic signed [CW-1:0] tex_u,
  input  wire logic signed [CW-1:0] tex_v,
  output logic                      job_valid,
  input  wire logic                 job_ready,
  output logic [10*(CW+1):0]        job_data
);
  localparam int DW = CW + 1;

  logic [1:0]           corner_count;
  logic signed [CW-1:0] p0 [3];
  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] t0 [2];
  logic signed [CW-1:0] t1 [2];
  logic signed [CW-1:0] pin [3];
  logic signed [DW-1:0] e0 [3];
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] du0, dv0, du1, dv1;
  logic                 third;
  logic                 take;

  function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    diff = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  assign pin[0] = pos_x;
  assign pin[1] = pos_y;
  assign pin[2] = pos_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0[k] = diff(p1[k], p0[k]);
      e1[k] = diff(pin[k], p0[k]);
    end
    du0 = diff(t1[0], t0[0]);
    dv0 = diff(t1[1], t0[1]);
    du1 = diff(tex_u, t0[0]);
    dv1 = diff(tex_v, t0[1]);
  end

  assign third     = (corner_count == tut_pkg::LAST_CORNER);
  assign in_ready  = !third || job_ready;
  assign job_valid = in_valid && third;
  assign take      = in_valid && in_ready;
  assign job_data  = {uv_present, e0[0], e0[1], e0[2], e1[0], e1[1], e1[2],
                      du0, dv0, du1, dv1};

  always_ff @(posedge clk) begin
    if (take && corner_count == 2'd0) begin
      for (int k = 0; k < 3; k++) p0[k] <= pin[k];
      t0[0] <= tex_u;
      t0[1] <= tex_v;
    end
    if (take && corner_count == 2'd1) begin
      for (int k = 0; k < 3; k++) p1[k] <= pin[k];
      t1[0] <= tex_u;
      t1[1] <= tex_v;
    end
    if (rst) begin
      corner_count <= 2'd0;
    end else if (take) begin
      corner_count <= third ? 2'd0 : corner_count + 2'd1;
    end
  end
endmodule
`default_nettype wire

// File: rtl/tut_back.sv
// Tangent back end: products, sign, normalize, square root, divide, output register.
// Uses tut_pkg; fed by tut_queue.
`default_nettype none
module tut_back #(
  parameter int CW = tut_pkg::COORD_WIDTH,
  parameter int FB = tut_pkg::FRAC_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire logic [10*(CW+1):0] job_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic signed [tut_pkg::OUT_WIDTH-1:0] tangent_x,
  output logic signed [tut_pkg::OUT_WIDTH-1:0] tangent_y,
  output logic signed [tut_pkg::OUT_WIDTH-1:0] tangent_z,
  output logic                 degenerate
);
  localparam int DW  = CW + 1;
  localparam int CK  = tut_pkg::MUL_CHUNK;
  localparam int NCH = (DW + CK - 1) / CK;
  localparam int BPW = NCH * CK;
  localparam int PW  = DW + BPW;
  localparam int AW0 = 2 * DW + 2;
  localparam int AW  = (AW0 > 46) ? AW0 : 46;
  localparam int OW  = tut_pkg::OUT_WIDTH;
  localparam int SB  = tut_pkg::STEP_BITS;
  localparam int QB  = tut_pkg::QUOT_BITS;
  localparam logic [63:0] DET_EPS = ((64'd1 << (2 * FB)) + 64'd50000) / 64'd100000;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MAG, S_NORM, S_SQ, S_SQRT, S_DINIT, S_DIV
  } state_t;

  state_t               state;
  logic                 done_pend;
  logic signed [DW-1:0] e0 [3];
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] du0, dv0, du1, dv1;
  logic                 dgn;
  logic [2:0]           pidx;
  logic [SB-1:0]        cnt;
  logic [DW-1:0]        opa;
  logic [BPW-1:0]       opb;
  logic [PW-1:0]        prod;
  logic                 pneg;
  logic signed [AW-1:0] det;
  logic signed [AW-1:0] v [3];
  logic [AW-1:0]        mag [3];
  logic                 vneg [3];
  logic                 detneg;
  logic [1:0]           sq_idx;
  logic [63:0]          sum;
  logic [63:0]          rt;
  logic [63:0]          bitv;
  logic [31:0]          len;
  logic [31:0]          rem [3];
  logic [31:0]          nlo [3];
  logic [QB-1:0]        quo [3];

  logic signed [DW-1:0] sel_a, sel_b;
  logic [DW+CK-1:0]     pp;
  logic [AW-1:0]        pterm;
  logic                 psub;
  logic [AW-1:0]        orv;
  logic [61:0]          sq;
  logic [63:0]          rtry;
  logic [61:0]          numv [3];
  logic [32:0]          r2 [3];

  function automatic logic [DW-1:0] abs_of(input logic signed [DW-1:0] x);
    abs_of = x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  function automatic logic [AW-1:0] wabs(input logic signed [AW-1:0] x);
    wabs = x[AW-1] ? AW'(-x) : AW'(x);
  endfunction

  always_comb begin
    case (pidx)
      3'd0:    begin sel_a = du0; sel_b = dv1;   end
      3'd1:    begin sel_a = du1; sel_b = dv0;   end
      3'd2:    begin sel_a = dv1; sel_b = e0[0]; end
      3'd3:    begin sel_a = dv0; sel_b = e1[0]; end
      3'd4:    begin sel_a = dv1; sel_b = e0[1]; end
      3'd5:    begin sel_a = dv0; sel_b = e1[1]; end
      3'd6:    begin sel_a = dv1; sel_b = e0[2]; end
      default: begin sel_a = dv0; sel_b = e1[2]; end
    endcase
    pp    = {{CK{1'b0}}, opa} * {{DW{1'b0}}, opb[BPW-1 -: CK]};
    pterm = AW'(prod);
    psub  = pneg ^ pidx[0];
    orv   = mag[0] | mag[1] | mag[2];
    sq    = {31'b0, mag[sq_idx][30:0]} * {31'b0, mag[sq_idx][30:0]};
    rtry  = rt + bitv;
    for (int k = 0; k < 3; k++) begin
      numv[k] = {1'b0, mag[k][30:0], 30'b0} + {31'b0, rt[31:1]};
      r2[k]   = {rem[k], nlo[k][31]};
    end
  end

  assign job_ready = (state == S_IDLE) && !done_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (done_pend && (!out_valid || out_ready)) begin
        out_valid  <= 1'b1;
        done_pend  <= 1'b0;
        degenerate <= dgn;
        tangent_x  <= dgn ? '0 : ((vneg[0] ^ detneg) ? OW'(-quo[0]) : OW'(quo[0]));
        tangent_y  <= dgn ? '0 : ((vneg[1] ^ detneg) ? OW'(-quo[1]) : OW'(quo[1]));
        tangent_z  <= dgn ? '0 : ((vneg[2] ^ detneg) ? OW'(-quo[2]) : OW'(quo[2]));
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            {dgn, e0[0], e0[1], e0[2], e1[0], e1[1], e1[2], du0, dv0, du1, dv1} <=
              {!job_data[10*DW], job_data[10*DW-1:0]};
            det  <= AW'(DET_EPS);
            for (int k = 0; k < 3; k++) v[k] <= '0;
            pidx <= 3'd0;
            cnt  <= '0;
            if (job_data[10*DW]) begin
              state <= S_MUL;
            end else begin
              done_pend <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (cnt == '0) begin
            opa  <= abs_of(sel_a);
            opb  <= BPW'(abs_of(sel_b));
            prod <= '0;
            pneg <= sel_a[DW-1] ^ sel_b[DW-1];
            cnt  <= cnt + 1'b1;
          end else if (cnt <= SB'(NCH)) begin
            prod <= (prod << CK) + PW'(pp);
            opb  <= opb << CK;
            cnt  <= cnt + 1'b1;
          end else begin
            case (pidx[2:1])
              2'd0:    det  <= psub ? det  - pterm : det  + pterm;
              2'd1:    v[0] <= psub ? v[0] - pterm : v[0] + pterm;
              2'd2:    v[1] <= psub ? v[1] - pterm : v[1] + pterm;
              default: v[2] <= psub ? v[2] - pterm : v[2] + pterm;
            endcase
            cnt  <= '0;
            pidx <= pidx + 3'd1;
            if (pidx == 3'd7) state <= S_MAG;
          end
        end
        S_MAG: begin
          for (int k = 0; k < 3; k++) begin
            mag[k]  <= wabs(v[k]);
            vneg[k] <= v[k][AW-1];
          end
          detneg <= det[AW-1];
          if (v[0] == '0 && v[1] == '0 && v[2] == '0) begin
            dgn       <= 1'b1;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (|orv[AW-1:39]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 8;
          end else if (|orv[38:31]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
          end else if (orv[30:23] == '0) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 8;
          end else if (!orv[30]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            sum    <= '0;
            sq_idx <= 2'd0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          sum    <= sum + {2'b0, sq};
          sq_idx <= sq_idx + 2'd1;
          if (sq_idx == 2'd2) begin
            rt    <= '0;
            bitv  <= 64'd1 << 62;
            cnt   <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sum >= rtry) begin
            sum <= sum - rtry;
            rt  <= (rt >> 1) + bitv;
          end else begin
            rt <= rt >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == SB'(tut_pkg::ROOT_STEPS - 1)) state <= S_DINIT;
        end
        S_DINIT: begin
          len   <= rt[31:0];
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (r2[k] >= {1'b0, len}) begin
              rem[k] <= 32'(r2[k] - {1'b0, len});
              quo[k] <= {quo[k][QB-2:0], 1'b1};
            end else begin
              rem[k] <= r2[k][31:0];
              quo[k] <= {quo[k][QB-2:0], 1'b0};
            end
            nlo[k] <= nlo[k] << 1;
          end
          if (cnt == SB'(QB - 1)) begin
            dgn       <= 1'b0;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DINIT) begin
        for (int k = 0; k < 3; k++) begin
          rem[k] <= {2'b0, numv[k][61:32]};
          nlo[k] <= numv[k][31:0];
          quo[k] <= '0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for triangle_uv_tangent_core: drives corner words and a uv_present
// flag, predicts each tangent word and checks it against the output channel.
// Depends on tut_pkg and the core RTL.
`default_nettype none
module tb;
  localparam int CW = tut_pkg::COORD_WIDTH;
  localparam int LIMIT = 1000000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 250;
  localparam longint DET_EPS =
    ((64'd1 << (2 * tut_pkg::FRAC_BITS)) + 64'd50000) / 64'd100000;

  typedef struct packed {
    logic [CW-1:0] px, py, pz, tu, tv;
  } corner_t;

  typedef struct packed {
    logic [31:0] tx, ty, tz;
    logic        degen;
  } tangent_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] tangent_x, tangent_y, tangent_z;
  logic degenerate;

  triangle_uv_tangent_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
    .out_valid(out_valid), .out_ready(out_ready),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .degenerate(degenerate)
  );

  always #10 clk = ~clk;

  corner_t  pending_corners[$];
  tangent_t expected_tangents[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 0;
  int  hold_reqs = 0;
  int  hold_seen = 0;

  logic            uv_on = 0;
  logic [1:0]      corner_cnt = 0;
  longint          held_pos[6];
  longint          held_tex[4];

  function automatic longint sx(logic [CW-1:0] x);
    return longint'($signed(x));
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Returns 1 when the corner closes a triangle; t then holds the tangent word.
  function automatic bit tangent_of_corner(corner_t c, output tangent_t t);
    longint p[3], e0[3], e1[3], du0, dv0, du1, dv1;
    logic signed [127:0] det, v[3], w0, w1, w2, w3;
    logic [127:0] mag[3];
    logic [63:0] m[3], sum, len, q;
    bit vneg[3];
    bit detneg;
    int L;
    p[0] = sx(c.px); p[1] = sx(c.py); p[2] = sx(c.pz);
    if (corner_cnt < tut_pkg::LAST_CORNER) begin
      for (int k = 0; k < 3; k++) held_pos[corner_cnt * 3 + k] = p[k];
      held_tex[corner_cnt * 2] = sx(c.tu);
      held_tex[corner_cnt * 2 + 1] = sx(c.tv);
      corner_cnt++;
      return 0;
    end
    corner_cnt = 0;
    t = '{tx: 0, ty: 0, tz: 0, degen: 1'b1};
    if (!uv_on) return 1;
    for (int k = 0; k < 3; k++) begin
      e0[k] = held_pos[3 + k] - held_pos[k];
      e1[k] = p[k] - held_pos[k];
    end
    du0 = held_tex[2] - held_tex[0];
    dv0 = held_tex[3] - held_tex[1];
    du1 = sx(c.tu) - held_tex[0];
    dv1 = sx(c.tv) - held_tex[1];
    w0 = du0; w1 = dv1; w2 = du1; w3 = dv0;
    det = w0 * w1 - w2 * w3 + DET_EPS;
    detneg = det < 0;
    L = 0;
    for (int k = 0; k < 3; k++) begin
      logic signed [127:0] a, b;
      a = e0[k];
      b = e1[k];
      v[k] = w1 * a - w3 * b;
      vneg[k] = v[k] < 0;
      mag[k] = vneg[k] ? -v[k] : v[k];
      for (int i = 0; i < 128; i++) if (mag[k][i] && i + 1 > L) L = i + 1;
    end
    if (L == 0) return 1;
    for (int k = 0; k < 3; k++) begin
      logic [127:0] s;
      s = (L > 31) ? (mag[k] >> (L - 31)) : (mag[k] << (31 - L));
      m[k] = s[63:0];
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = isqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = ((m[k] << 30) + len / 2) / len;
      if (vneg[k] != detneg) q = -q;
      if (k == 0) t.tx = q[31:0];
      else if (k == 1) t.ty = q[31:0];
      else t.tz = q[31:0];
    end
    t.degen = 1'b0;
    return 1;
  endfunction

  // Input acceptance, prediction and output check share one process.
  always @(posedge clk) begin
    tangent_t t, e;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_tangents.size() == 0) begin
        $error("unexpected tangent word %h %h %h %b",
               tangent_x, tangent_y, tangent_z, degenerate);
        errors++;
      end else begin
        e = expected_tangents.pop_front();
        if (tangent_x !== e.tx) begin
          $error("tangent_x expected %h got %h", e.tx, tangent_x); errors++;
        end
        if (tangent_y !== e.ty) begin
          $error("tangent_y expected %h got %h", e.ty, tangent_y); errors++;
        end
        if (tangent_z !== e.tz) begin
          $error("tangent_z expected %h got %h", e.tz, tangent_z); errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate expected %b got %b", e.degen, degenerate); errors++;
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      if (tangent_of_corner('{pos_x, pos_y, pos_z, tex_u, tex_v}, t))
        expected_tangents.insert(expected_tangents.size(), t);
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Corner driver: advance on acceptance, idle in short random bursts.
  bit in_took = 0;
  int in_gap = 0;
  always @(posedge clk) in_took <= in_valid && in_ready;

  always @(negedge clk) begin
    corner_t c;
    if (!rst && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 3);
        in_valid <= 0;
      end else if (pending_corners.size() != 0) begin
        c = pending_corners.pop_front();
        pos_x <= c.px; pos_y <= c.py; pos_z <= c.pz;
        tex_u <= c.tu; tex_v <= c.tv;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Result receiver: random stall bursts plus an occasional long hold.
  int stall = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      stall = LONG_HOLD;
    end
    if (stall > 0) begin
      stall--;
      out_ready <= 0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall = $urandom_range(0, 3);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return CW'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      3: return CW'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      default: return CW'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  function automatic corner_t rand_corner();
    return '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
  endfunction

  task automatic add_tri(corner_t a, corner_t b, corner_t c);
    pending_corners.insert(pending_corners.size(), a);
    pending_corners.insert(pending_corners.size(), b);
    pending_corners.insert(pending_corners.size(), c);
  endtask

  task automatic add_random(int n);
    corner_t a, b, c;
    repeat (n) begin
      a = rand_corner();
      b = rand_corner();
      c = rand_corner();
      case ($urandom_range(0, 9))
        0: b = a;
        1: c = a;
        2: begin b.tu = a.tu; b.tv = a.tv; end
        3: begin c.px = a.px; c.py = a.py; c.pz = a.pz; end
        default: ;
      endcase
      add_tri(a, b, c);
    end
  endtask

  task automatic write_uv(logic val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    uv_on = val;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (pending_corners.size() != 0 || in_valid || expected_tangents.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;

  initial begin
    corner_t z;
    z = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    write_uv(1);
    add_tri('{0, 0, 0, 0, 0}, '{32'h10000, 0, 0, 32'h10000, 0},
            '{0, 32'h10000, 0, 0, 32'h10000});
    add_tri('{MINV, MINV, MINV, MINV, MINV}, '{MAXV, MAXV, MAXV, MAXV, MAXV},
            '{MINV, MAXV, MINV, MAXV, MINV});
    add_tri('{MAXV, MINV, MAXV, MINV, MAXV}, '{MINV, MAXV, MINV, MAXV, MAXV},
            '{MAXV, MAXV, MINV, MINV, MINV});
    add_tri('{5, 5, 5, 1, 2}, '{5, 5, 5, 3, 7}, '{5, 5, 5, 9, 4});
    add_tri('{1, 2, 3, 0, 0}, '{4, 5, 6, 1, 0}, '{7, 1, 9, 0, -42950});
    add_tri('{1, 2, 3, 0, 0}, '{-4, 5, 6, 1, 0}, '{7, -1, 9, 0, -42951});
    add_tri('{0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0}, '{0, 1, 0, 0, 0});
    add_tri('{0, 0, 0, 0, 0}, '{32'h7000_0000, 3, 1, 0, 1}, '{2, -5, 32'h9000_0000, 1, -1});
    drain();

    write_uv(0);
    add_tri(z, '{1, 2, 3, 4, 5}, '{9, 8, 7, 6, 5});
    add_random(10);
    drain();

    write_uv(1);
    add_random(100);
    hold_reqs++;
    add_random(100);
    drain();
    hold_reqs++;
    add_random(20);
    drain();

    write_uv(0);
    add_random(20);
    drain();

    write_uv(1);
    add_random(60);
    drain();
    quiet = 1;
    add_random(160);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: triangle_uv_tangent_core.f
+incdir+rtl
rtl/tut_pkg.sv
rtl/tut_queue.sv
rtl/tut_front.sv
rtl/tut_back.sv
rtl/triangle_uv_tangent_core.sv
sim/tb.sv
